// ===== hw/rtl/ncdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared types and fixed-point constants of the normal CDF evaluator.
// ----------------------------------------------------------------------------
package ncdf_pkg;

  typedef enum logic [1:0] {
    RegMean   = 2'd0,
    RegStdDev = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic dge;
    logic far;
  } flags_t;

  localparam logic [31:0] InvSqrt2Q32 = 32'd3037000500;
  localparam logic [31:0] PQ32 =
    32'(((64'd3275911 << 32) + 64'd5000000) / 64'd10000000);
  localparam logic [35:0] ZMaxQ32 = 36'h6_0000_0000;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  localparam logic [26:0] ExpNInv = 27'((64'd1 << 56) / 64'd744261118);

  localparam longint unsigned CoefA1 =
    ((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned CoefA2 =
    ((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned CoefA3 =
    ((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned CoefA4 =
    ((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned CoefA5 =
    ((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000;

  localparam int NumHorner = 5;
  localparam logic signed [33:0] PolyA5 = 34'(CoefA5);
  localparam logic signed [33:0] PolyAdd [NumHorner] = '{
    -34'(CoefA4), 34'(CoefA3), -34'(CoefA2), 34'(CoefA1), 34'sd0
  };
  localparam logic signed [33:0] PolyMax = 34'sh0_8000_0000;

  localparam int NumTaylor = 13;
  localparam logic [34:0] TaylorRecip [NumTaylor] = '{
    35'((64'd1 << 34)),
    35'(((64'd1 << 34) + 64'd1) / 64'd2),
    35'(((64'd1 << 34) + 64'd2) / 64'd3),
    35'(((64'd1 << 34) + 64'd3) / 64'd4),
    35'(((64'd1 << 34) + 64'd4) / 64'd5),
    35'(((64'd1 << 34) + 64'd5) / 64'd6),
    35'(((64'd1 << 34) + 64'd6) / 64'd7),
    35'(((64'd1 << 34) + 64'd7) / 64'd8),
    35'(((64'd1 << 34) + 64'd8) / 64'd9),
    35'(((64'd1 << 34) + 64'd9) / 64'd10),
    35'(((64'd1 << 34) + 64'd10) / 64'd11),
    35'(((64'd1 << 34) + 64'd11) / 64'd12),
    35'(((64'd1 << 34) + 64'd12) / 64'd13)
  };

endpackage

// ===== hw/rtl/ncdf_div.sv =====
// ----------------------------------------------------------------------------
// ncdf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ncdf_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 36,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] low_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] div_q  [QW];
  logic [QW-1:0] lq_q   [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic          vin;
    logic [DW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] lin;
    logic [SW-1:0] sin;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          ge;

    if (s == 0) begin : g_head
      assign vin = vld_i;
      assign rin = rem_i;
      assign din = div_i;
      assign lin = low_i;
      assign sin = side_i;
    end else begin : g_body
      assign vin = vld_q[s-1];
      assign rin = rem_q[s-1];
      assign din = div_q[s-1];
      assign lin = lq_q[s-1];
      assign sin = side_q[s-1];
    end

    assign trial = {rin, lin[QW-1]};
    assign diff  = {1'b0, trial} - {2'b00, din};
    assign ge    = !diff[DW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        div_q[s]  <= din;
        lq_q[s]   <= {lin[QW-2:0], ge};
        side_q[s] <= sin;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = lq_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

// ===== hw/rtl/ncdf_erf.sv =====
// ----------------------------------------------------------------------------
// ncdf_erf
// Pipelined erf(|z|): Horner polynomial in t, exp(-z^2) by range reduction
// and Taylor series, then the product and the far-tail override.
// ----------------------------------------------------------------------------
module ncdf_erf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [30:0]          t_i,
  input  logic [35:0]          w_i,
  input  ncdf_pkg::flags_t     flags_i,
  output logic                 vld_o,
  output logic [30:0]          erf_o,
  output ncdf_pkg::flags_t     flags_o
);

  localparam int NH = ncdf_pkg::NumHorner;
  localparam int NT = ncdf_pkg::NumTaylor;

  // Horner stages
  logic                    pa_vld_q  [NH];
  ncdf_pkg::flags_t        pa_flg_q  [NH];
  logic [30:0]             pa_t_q    [NH];
  logic [35:0]             pa_w_q    [NH];
  logic                    pa_neg_q  [NH];
  logic [63:0]             pa_prod_q [NH];
  logic                    pb_vld_q  [NH];
  ncdf_pkg::flags_t        pb_flg_q  [NH];
  logic [30:0]             pb_t_q    [NH];
  logic [35:0]             pb_w_q    [NH];
  logic signed [33:0]      pb_acc_q  [NH];

  for (genvar j = 0; j < NH; j++) begin : g_horner
    logic                 vin;
    ncdf_pkg::flags_t     fin;
    logic [30:0]          tin;
    logic [35:0]          win;
    logic signed [33:0]   ain;
    logic signed [33:0]   aneg;
    logic [32:0]          mag;
    logic [63:0]          rnd;
    logic signed [33:0]   smag;

    if (j == 0) begin : g_head
      assign vin = vld_i;
      assign fin = flags_i;
      assign tin = t_i;
      assign win = w_i;
      assign ain = ncdf_pkg::PolyA5;
    end else begin : g_body
      assign vin = pb_vld_q[j-1];
      assign fin = pb_flg_q[j-1];
      assign tin = pb_t_q[j-1];
      assign win = pb_w_q[j-1];
      assign ain = pb_acc_q[j-1];
    end

    assign aneg = -ain;
    assign mag  = ain[33] ? aneg[32:0] : ain[32:0];
    assign rnd  = pa_prod_q[j] + (64'd1 << 29);
    assign smag = signed'({1'b0, rnd[62:30]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pa_vld_q[j] <= 1'b0;
        pb_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        pa_vld_q[j] <= vin;
        pb_vld_q[j] <= pa_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_flg_q[j]  <= fin;
        pa_t_q[j]    <= tin;
        pa_w_q[j]    <= win;
        pa_neg_q[j]  <= ain[33];
        pa_prod_q[j] <= 64'(mag) * 64'(tin);
        pb_flg_q[j]  <= pa_flg_q[j];
        pb_t_q[j]    <= pa_t_q[j];
        pb_w_q[j]    <= pa_w_q[j];
        pb_acc_q[j]  <= (pa_neg_q[j] ? -smag : smag) + ncdf_pkg::PolyAdd[j];
      end
    end
  end

  // Range reduction: w = n * ln2 + r
  logic                 x1_vld_q, x2_vld_q, x3_vld_q;
  ncdf_pkg::flags_t     x1_flg_q, x2_flg_q, x3_flg_q;
  logic [31:0]          x1_poly_q, x2_poly_q, x3_poly_q;
  logic [35:0]          x1_w_q;
  logic [58:0]          x1_prod_q;
  logic [6:0]           x2_n_q, x3_n_q;
  logic [30:0]          x2_r_q;
  logic [29:0]          x3_r_q;
  logic signed [33:0]   acc5;
  logic [31:0]          poly_d;
  logic [6:0]           nest;
  logic [36:0]          r0_full;
  logic [31:0]          r0_cmp;
  logic                 r_ge;

  assign acc5   = pb_acc_q[NH-1];
  assign poly_d = acc5[33] ? 32'd0 :
                  (acc5 > ncdf_pkg::PolyMax) ? 32'h8000_0000 : acc5[31:0];
  assign nest    = x1_prod_q[58:52];
  assign r0_full = {1'b0, x1_w_q} - 37'(37'(nest) * 37'(ncdf_pkg::Ln2Q30));
  assign r0_cmp  = {1'b0, x2_r_q} - {2'b00, ncdf_pkg::Ln2Q30};
  assign r_ge    = !r0_cmp[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
      x3_vld_q <= 1'b0;
    end else if (en_i) begin
      x1_vld_q <= pb_vld_q[NH-1];
      x2_vld_q <= x1_vld_q;
      x3_vld_q <= x2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_flg_q  <= pb_flg_q[NH-1];
      x1_poly_q <= poly_d;
      x1_w_q    <= pb_w_q[NH-1];
      x1_prod_q <= 59'(pb_w_q[NH-1][35:4]) * 59'(ncdf_pkg::ExpNInv);
      x2_flg_q  <= x1_flg_q;
      x2_poly_q <= x1_poly_q;
      x2_n_q    <= nest;
      x2_r_q    <= r0_full[30:0];
      x3_flg_q  <= x2_flg_q;
      x3_poly_q <= x2_poly_q;
      x3_n_q    <= r_ge ? x2_n_q + 7'd1 : x2_n_q;
      x3_r_q    <= r_ge ? r0_cmp[29:0] : x2_r_q[29:0];
    end
  end

  // Taylor series of exp(-r)
  logic                 ta_vld_q  [NT];
  ncdf_pkg::flags_t     ta_flg_q  [NT];
  logic [31:0]          ta_poly_q [NT];
  logic [6:0]           ta_n_q    [NT];
  logic [29:0]          ta_r_q    [NT];
  logic signed [32:0]   ta_sum_q  [NT];
  logic [60:0]          ta_prod_q [NT];
  logic                 tb_vld_q  [NT];
  ncdf_pkg::flags_t     tb_flg_q  [NT];
  logic [31:0]          tb_poly_q [NT];
  logic [6:0]           tb_n_q    [NT];
  logic [29:0]          tb_r_q    [NT];
  logic signed [32:0]   tb_sum_q  [NT];
  logic [64:0]          tb_quot_q [NT];

  for (genvar i = 0; i < NT; i++) begin : g_taylor
    logic                 vin;
    ncdf_pkg::flags_t     fin;
    logic [31:0]          pin;
    logic [6:0]           nin;
    logic [29:0]          rin;
    logic [30:0]          term;
    logic signed [32:0]   sin;

    if (i == 0) begin : g_head
      assign vin  = x3_vld_q;
      assign fin  = x3_flg_q;
      assign pin  = x3_poly_q;
      assign nin  = x3_n_q;
      assign rin  = x3_r_q;
      assign term = 31'h4000_0000;
      assign sin  = 33'sh0_4000_0000;
    end else begin : g_body
      assign vin  = tb_vld_q[i-1];
      assign fin  = tb_flg_q[i-1];
      assign pin  = tb_poly_q[i-1];
      assign nin  = tb_n_q[i-1];
      assign rin  = tb_r_q[i-1];
      assign term = tb_quot_q[i-1][64:34];
      if (i % 2 == 1) begin : g_sub
        assign sin = tb_sum_q[i-1] - signed'({2'b00, term});
      end else begin : g_add
        assign sin = tb_sum_q[i-1] + signed'({2'b00, term});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ta_vld_q[i] <= 1'b0;
        tb_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        ta_vld_q[i] <= vin;
        tb_vld_q[i] <= ta_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ta_flg_q[i]  <= fin;
        ta_poly_q[i] <= pin;
        ta_n_q[i]    <= nin;
        ta_r_q[i]    <= rin;
        ta_sum_q[i]  <= sin;
        ta_prod_q[i] <= 61'(term) * 61'(rin);
        tb_flg_q[i]  <= ta_flg_q[i];
        tb_poly_q[i] <= ta_poly_q[i];
        tb_n_q[i]    <= ta_n_q[i];
        tb_r_q[i]    <= ta_r_q[i];
        tb_sum_q[i]  <= ta_sum_q[i];
        tb_quot_q[i] <= 65'(ta_prod_q[i][59:30]) * 65'(ncdf_pkg::TaylorRecip[i]);
      end
    end
  end

  // Final term, scale by 2^-n, product with the polynomial
  logic signed [32:0]   fin_sum;
  logic [30:0]          spos;
  logic [39:0]          rnd_sh;
  logic [30:0]          e_d;
  logic                 sh_vld_q, p1_vld_q, p2_vld_q;
  ncdf_pkg::flags_t     sh_flg_q, p1_flg_q, p2_flg_q;
  logic [31:0]          sh_poly_q;
  logic [30:0]          sh_e_q;
  logic [62:0]          p1_pm_q;
  logic [62:0]          pm_rnd;
  logic [32:0]          pe;
  logic [30:0]          erf_d;
  logic [30:0]          p2_erf_q;

  assign fin_sum = tb_sum_q[NT-1] - signed'({2'b00, tb_quot_q[NT-1][64:34]});
  assign spos    = fin_sum[32] ? 31'd0 : fin_sum[30:0];

  always_comb begin
    rnd_sh = '0;
    priority if (tb_n_q[NT-1] == 7'd0) begin
      e_d = spos;
    end else if (tb_n_q[NT-1] >= 7'd40) begin
      e_d = '0;
    end else begin
      rnd_sh = ({9'd0, spos} + (40'd1 << (tb_n_q[NT-1] - 7'd1))) >> tb_n_q[NT-1];
      e_d    = rnd_sh[30:0];
    end
  end

  assign pm_rnd = p1_pm_q + (63'd1 << 29);
  assign pe     = pm_rnd[62:30];
  assign erf_d  = p1_flg_q.far ? 31'h4000_0000 :
                  (pe >= 33'h0_4000_0000) ? 31'd0 : 31'(33'h0_4000_0000 - pe);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en_i) begin
      sh_vld_q <= tb_vld_q[NT-1];
      p1_vld_q <= sh_vld_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_flg_q  <= tb_flg_q[NT-1];
      sh_poly_q <= tb_poly_q[NT-1];
      sh_e_q    <= e_d;
      p1_flg_q  <= sh_flg_q;
      p1_pm_q   <= 63'(sh_poly_q) * 63'(sh_e_q);
      p2_flg_q  <= p1_flg_q;
      p2_erf_q  <= erf_d;
    end
  end

  assign vld_o   = p2_vld_q;
  assign erf_o   = p2_erf_q;
  assign flags_o = p2_flg_q;

endmodule

// ===== hw/rtl/normal_cdf_eval_top.sv =====
// ----------------------------------------------------------------------------
// normal_cdf_eval_top
// Normal CDF of a Q16.16 sample for a configured mean and deviation, Q1.31 out.
// ----------------------------------------------------------------------------
//  channel  signals                              beat
//  in       in_valid_i, in_stall_o, sample_i     one sample
//  out      out_valid_o, out_stall_i, cdf_o      one CDF value
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i      one register write
//
//  One beat in and one out per cycle while the output is not stalled: two
//  bit-serial divider pipelines (36 and 31 stages) and the 14-term exp series
//  set the depth. Reset empties the pipeline and loads mean 0, deviation 1.0.
//  A stalled output freezes every stage, the input stalls with it.
// ----------------------------------------------------------------------------
module normal_cdf_eval_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] cdf_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] mean_q, std_dev_q;
  logic        en;
  logic        out_vld_q;
  logic [31:0] cdf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q    <= 32'd0;
      std_dev_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ncdf_pkg::RegMean:   mean_q    <= cfg_data_i;
        ncdf_pkg::RegStdDev: std_dev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // difference and magnitude
  logic [32:0] d;
  logic [32:0] dneg;
  logic        s1_vld_q, s2_vld_q;
  logic        s1_dge_q, s2_dge_q;
  logic [32:0] s1_ad_q;
  logic [64:0] s2_num_q;

  assign d    = {sample_i[31], sample_i} - {mean_q[31], mean_q};
  assign dneg = -d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dge_q <= !d[32];
      s1_ad_q  <= d[32] ? dneg : d;
      s2_dge_q <= s1_dge_q;
      s2_num_q <= 65'(s1_ad_q) * 65'(ncdf_pkg::InvSqrt2Q32);
    end
  end

  // |z| = |d| / (sigma sqrt 2), Q.32
  ncdf_pkg::flags_t flg1_in, flg1_out;
  logic             dv1_vld;
  logic [35:0]      q1;
  logic [1:0]       side1;

  assign flg1_in.dge = s2_dge_q;
  assign flg1_in.far = ({3'b000, s2_num_q[64:36]} >= std_dev_q);
  assign flg1_out    = side1;

  ncdf_div #(
    .DW(32),
    .QW(36),
    .SW(2)
  ) u_div_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .rem_i  ({3'b000, s2_num_q[64:36]}),
    .div_i  (std_dev_q),
    .low_i  (s2_num_q[35:0]),
    .side_i (flg1_in),
    .vld_o  (dv1_vld),
    .quo_o  (q1),
    .side_o (side1)
  );

  // z^2 and the denominator of t
  logic             s3_vld_q, s4_vld_q;
  ncdf_pkg::flags_t s3_flg_q, s4_flg_q;
  logic [61:0]      s3_sq_q;
  logic [64:0]      s3_pz_q;
  logic [35:0]      s4_w_q;
  logic [31:0]      s4_den_q;
  logic [62:0]      sq_rnd;
  logic [65:0]      pz_rnd;

  assign sq_rnd = {1'b0, s3_sq_q} + (63'd1 << 25);
  assign pz_rnd = {1'b0, s3_pz_q} + (66'd1 << 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= dv1_vld;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_flg_q.dge <= flg1_out.dge;
      s3_flg_q.far <= flg1_out.far || (q1 >= ncdf_pkg::ZMaxQ32);
      s3_sq_q      <= 62'(q1[34:4]) * 62'(q1[34:4]);
      s3_pz_q      <= 65'(ncdf_pkg::PQ32) * 65'(q1[34:2]);
      s4_flg_q     <= s3_flg_q;
      s4_w_q       <= sq_rnd[61:26];
      s4_den_q     <= 32'h4000_0000 + pz_rnd[63:32];
    end
  end

  // t = 1 / (1 + p|z|), Q.30
  logic             dv2_vld;
  logic [30:0]      t2;
  logic [37:0]      side2;
  ncdf_pkg::flags_t flg2;
  logic [35:0]      w2;

  assign {flg2, w2} = side2;

  ncdf_div #(
    .DW(32),
    .QW(31),
    .SW(38)
  ) u_div_t (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .rem_i  (32'd1 << 29),
    .div_i  (s4_den_q),
    .low_i  (s4_den_q[31:1]),
    .side_i ({s4_flg_q, s4_w_q}),
    .vld_o  (dv2_vld),
    .quo_o  (t2),
    .side_o (side2)
  );

  logic             erf_vld;
  logic [30:0]      erf30;
  ncdf_pkg::flags_t erf_flg;

  ncdf_erf u_erf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (dv2_vld),
    .t_i     (t2),
    .w_i     (w2),
    .flags_i (flg2),
    .vld_o   (erf_vld),
    .erf_o   (erf30),
    .flags_o (erf_flg)
  );

  // sign restore and step for zero deviation
  logic [31:0] cdf_d;

  always_comb begin
    priority if (std_dev_q == 32'd0) begin
      cdf_d = erf_flg.dge ? 32'h8000_0000 : 32'd0;
    end else if (erf_flg.dge) begin
      cdf_d = 32'h4000_0000 + 32'(erf30);
    end else begin
      cdf_d = 32'h4000_0000 - 32'(erf30);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= erf_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdf_q <= cdf_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cdf_o       = cdf_q;

endmodule
